// ----- sv/neps_pkg.sv -----
// Package for the nearest edge pixel search unit.
// Holds the sizing constants, the transfer and control structs and the state codes.
// Has no dependencies; every other file of the block but neps_ram imports it.
package neps_pkg;

    localparam int MAX_COLS      = 512;
    localparam int MAX_ROWS      = 512;
    localparam int SEARCH_RADIUS = 5;

    localparam int POS_W  = 9;
    localparam int SIZE_W = 10;
    localparam int CRD_W  = POS_W + 2;
    localparam int MAG_W  = CRD_W - 1;

    localparam int POS_LIMIT = 2 ** POS_W;
    localparam int COLS_LIM  = (MAX_COLS < POS_LIMIT) ? MAX_COLS : POS_LIMIT;
    localparam int ROWS_LIM  = (MAX_ROWS < POS_LIMIT) ? MAX_ROWS : POS_LIMIT;

    localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    localparam int RW   = $clog2(SEARCH_RADIUS + 1);
    localparam int KW   = $clog2(2 * SEARCH_RADIUS);
    localparam int DX_W = $clog2(SEARCH_RADIUS + 1) + 1;
    localparam int D_W  = $clog2(2 * SEARCH_RADIUS * SEARCH_RADIUS + 1);

    localparam logic [SIZE_W-1:0] RESET_COLS = SIZE_W'(512);
    localparam logic [SIZE_W-1:0] RESET_ROWS = SIZE_W'(512);

    localparam logic REG_IMAGE_COLS = 1'b0;
    localparam logic REG_IMAGE_ROWS = 1'b1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        SIDE_RIGHT = 2'd0,
        SIDE_DOWN  = 2'd1,
        SIDE_LEFT  = 2'd2,
        SIDE_UP    = 2'd3
    } side_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FLUSH  = 2'd2,
        ST_REPORT = 2'd3
    } state_t;

    typedef struct packed {
        op_t              operation;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             edge_bit;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] nearest_x;
        logic [POS_W-1:0] nearest_y;
    } result_t;

    typedef struct packed {
        logic write;
        logic load;
        logic step;
    } ctl_t;

    typedef struct packed {
        logic last;
    } stat_t;

endpackage

// ----- sv/neps_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; width and depth come from its parameters.
module neps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/neps_ctrl.sv -----
// Controller state machine of the nearest edge pixel search unit.
// Depends on neps_pkg; drives the datapath through ctl_t and watches stat_t.
module neps_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  neps_pkg::op_t   operation,
    input  neps_pkg::stat_t stat,
    output neps_pkg::ctl_t  ctl,
    output logic            busy,
    output logic            done
);
    import neps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && operation == OP_QUERY)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:  state_next = ST_REPORT;
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl   = '0;
        busy  = 1'b1;
        done  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                ctl.write = start && operation == OP_WRITE;
                ctl.load  = start && operation == OP_QUERY;
            end
            ST_SCAN:   ctl.step = 1'b1;
            ST_FLUSH:  ctl.step = 1'b0;
            ST_REPORT: done     = 1'b1;
            default:   busy     = 1'b1;
        endcase
    end

endmodule

// ----- sv/neps_dp.sv -----
// Datapath of the nearest edge pixel search unit: size registers, ring walker,
// edge map memory and the running best candidate.
// Depends on neps_pkg and neps_ram.
module neps_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  neps_pkg::ctl_t               ctl,
    output neps_pkg::stat_t              stat,
    input  neps_pkg::item_t              item,
    output neps_pkg::result_t            result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [neps_pkg::SIZE_W-1:0]  cfg_data
);
    import neps_pkg::*;

    logic [SIZE_W-1:0] cols_reg, cols_next;
    logic [SIZE_W-1:0] rows_reg, rows_next;

    logic [POS_W-1:0]        px_reg, px_next;
    logic [POS_W-1:0]        py_reg, py_next;
    logic signed [CRD_W-1:0] x_reg, x_next;
    logic signed [CRD_W-1:0] y_reg, y_next;
    logic [RW-1:0]           r_reg, r_next;
    side_t                   side_reg, side_next;
    logic [KW-1:0]           k_reg, k_next;

    logic             rd_valid_reg, rd_valid_next;
    logic [POS_W-1:0] cand_x_reg, cand_x_next;
    logic [POS_W-1:0] cand_y_reg, cand_y_next;
    logic [D_W-1:0]   dist_reg, dist_next;

    logic             found_reg, found_next;
    logic [D_W-1:0]   best_reg, best_next;
    logic [POS_W-1:0] bx_reg, bx_next;
    logic [POS_W-1:0] by_reg, by_next;

    logic signed [CRD_W-1:0]  px_ext, py_ext;
    logic [MAG_W-1:0]         x_mag, y_mag;
    logic                     in_image;
    logic [KW-1:0]            k_end;
    logic signed [DX_W-1:0]   dx, dy;
    logic signed [2*DX_W-1:0] dx2, dy2;
    logic                     map_we;
    logic [MAP_AW-1:0]        waddr, raddr;
    logic                     map_q;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_COLS: cols_next = cfg_data;
                REG_IMAGE_ROWS: rows_next = cfg_data;
                default:        cols_next = cols_reg;
            endcase
        end
    end

    assign px_ext = signed'(CRD_W'(px_reg));
    assign py_ext = signed'(CRD_W'(py_reg));
    assign x_mag  = x_reg[MAG_W-1:0];
    assign y_mag  = y_reg[MAG_W-1:0];

    assign in_image = !x_reg[CRD_W-1] && !y_reg[CRD_W-1]
        && (CRD_W'(x_mag) < CRD_W'(cols_reg)) && (int'(x_mag) < COLS_LIM)
        && (CRD_W'(y_mag) < CRD_W'(rows_reg)) && (int'(y_mag) < ROWS_LIM);

    assign k_end     = KW'({r_reg, 1'b0} - (RW + 1)'(1));
    assign stat.last = (r_reg == RW'(SEARCH_RADIUS)) && (side_reg == SIDE_UP)
        && (k_reg == k_end);

    always_comb
    begin
        px_next   = px_reg;
        py_next   = py_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        side_next = side_reg;
        k_next    = k_reg;
        if (ctl.load)
        begin
            px_next   = item.pos_x;
            py_next   = item.pos_y;
            x_next    = signed'(CRD_W'(item.pos_x)) - CRD_W'(1);
            y_next    = signed'(CRD_W'(item.pos_y)) - CRD_W'(1);
            r_next    = RW'(1);
            side_next = SIDE_RIGHT;
            k_next    = '0;
        end
        else if (ctl.step)
        begin
            case (side_reg)
                SIDE_RIGHT: x_next = x_reg + CRD_W'(1);
                SIDE_DOWN:  y_next = y_reg + CRD_W'(1);
                SIDE_LEFT:  x_next = x_reg - CRD_W'(1);
                SIDE_UP:    y_next = y_reg - CRD_W'(1);
                default:    x_next = x_reg;
            endcase
            if (k_reg == k_end)
            begin
                k_next = '0;
                case (side_reg)
                    SIDE_RIGHT: side_next = SIDE_DOWN;
                    SIDE_DOWN:  side_next = SIDE_LEFT;
                    SIDE_LEFT:  side_next = SIDE_UP;
                    SIDE_UP:
                    begin
                        side_next = SIDE_RIGHT;
                        r_next    = r_reg + RW'(1);
                        x_next    = px_ext - CRD_W'(r_reg) - CRD_W'(1);
                        y_next    = py_ext - CRD_W'(r_reg) - CRD_W'(1);
                    end
                    default:    side_next = SIDE_RIGHT;
                endcase
            end
            else
            begin
                k_next = k_reg + KW'(1);
            end
        end
    end

    assign dx  = DX_W'(x_reg - px_ext);
    assign dy  = DX_W'(y_reg - py_ext);
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;

    assign rd_valid_next = ctl.step && in_image;
    assign cand_x_next   = POS_W'(x_mag);
    assign cand_y_next   = POS_W'(y_mag);
    assign dist_next     = D_W'(dx2) + D_W'(dy2);

    always_comb
    begin
        found_next = found_reg;
        best_next  = best_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        if (ctl.load)
        begin
            found_next = 1'b0;
            best_next  = '0;
            bx_next    = '0;
            by_next    = '0;
        end
        else if (rd_valid_reg && map_q && (!found_reg || dist_reg < best_reg))
        begin
            found_next = 1'b1;
            best_next  = dist_reg;
            bx_next    = cand_x_reg;
            by_next    = cand_y_reg;
        end
    end

    assign map_we = ctl.write && (int'(item.pos_x) < MAX_COLS)
        && (int'(item.pos_y) < MAX_ROWS);
    assign waddr  = MAP_AW'(item.pos_y) * MAP_AW'(MAX_COLS) + MAP_AW'(item.pos_x);
    assign raddr  = MAP_AW'(y_mag) * MAP_AW'(MAX_COLS) + MAP_AW'(x_mag);

    neps_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (waddr),
        .wdata (item.edge_bit),
        .raddr (raddr),
        .rdata (map_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= RESET_COLS;
            rows_reg     <= RESET_ROWS;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        r_reg      <= r_next;
        side_reg   <= side_next;
        k_reg      <= k_next;
        cand_x_reg <= cand_x_next;
        cand_y_reg <= cand_y_next;
        dist_reg   <= dist_next;
        best_reg   <= best_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
    end

    assign result.found     = found_reg;
    assign result.nearest_x = bx_reg;
    assign result.nearest_y = by_reg;

endmodule

// ----- sv/nearest_edge_pixel_search_unit.sv -----
// Top level of the nearest edge pixel search unit.
// Depends on neps_pkg, neps_ctrl and neps_dp (which holds the neps_ram edge map).
//
// Usage: an item is taken at a rising edge where start is high and busy is low.
// A write item stores one edge map bit in that edge and leaves busy low, so
// writes can follow every cycle; it gives no result.
// A query item raises busy through the scan, flush and report states. The 120
// positions of rings one to five are walked one per cycle through the single
// read port of the edge map, the flush state takes the last read into the
// compare, and the result stands on result for exactly one cycle with done high,
// in the report state. The next item is taken in the cycle after that.
// The receiver cannot stall: each result is a transfer in the cycle it shows.
// The size registers are written through cfg_valid, cfg_index and cfg_data;
// cfg_ready is always high and a write lands at once.
// Reset sets both sizes to 512 and returns the block to idle; the edge map
// is not cleared and must be written before it is queried.
module nearest_edge_pixel_search_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  neps_pkg::item_t              item,
    output logic                         done,
    output neps_pkg::result_t            result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [neps_pkg::SIZE_W-1:0]  cfg_data
);
    import neps_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    neps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .stat      (stat),
        .ctl       (ctl),
        .busy      (busy),
        .done      (done)
    );

    neps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .item      (item),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- sv/neps_checker.sv -----
// Port-level checker for the nearest edge pixel search unit.
// Depends on neps_pkg; bound to nearest_edge_pixel_search_unit below.
module neps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input neps_pkg::item_t              item,
    input logic                         done,
    input neps_pkg::result_t            result
);
    import neps_pkg::*;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done was high for more than one cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.operation == OP_QUERY |=> busy && !done)
        else $error("query transfer did not raise busy");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.operation == OP_WRITE |=> !busy && !done)
        else $error("write transfer held the block or gave a result");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.found |-> result.nearest_x == '0 && result.nearest_y == '0)
        else $error("miss result carries a nonzero position");

endmodule

bind nearest_edge_pixel_search_unit neps_checker u_neps_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

// ----- tb/sv/nearest_edge_pixel_search_unit_tb.sv -----
// Testbench for nearest_edge_pixel_search_unit: loads edge map windows, runs nearest-edge
// queries under several image sizes, checks each result by local predictor or typed row.
// Depends on neps_pkg and the nearest_edge_pixel_search_unit RTL.
`timescale 1ns / 1ps

module nearest_edge_pixel_search_unit_tb;

    import neps_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 130;

    typedef enum logic [1:0] {
        ROW_COLS  = 2'd0,
        ROW_ROWS  = 2'd1,
        ROW_WRITE = 2'd2,
        ROW_QUERY = 2'd3
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [SIZE_W-1:0] val;
        logic [POS_W-1:0]  y;
        logic              e;
        logic              typed;
        result_t           exp;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    item_t             item = '0;
    logic              done;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = 1'b0;
    logic [SIZE_W-1:0] cfg_data = '0;

    bit        edge_img [0:MAX_ROWS-1][0:MAX_COLS-1];
    bit        px_loaded [0:MAX_ROWS-1][0:MAX_COLS-1];
    int        eff_cols = COLS_LIM;
    int        eff_rows = ROWS_LIM;
    result_t   nearest_due [$];
    result_t   want;
    stim_row_t dir_rows [$];
    int        items_sent = 0;
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        no_idle = 1'b0;

    nearest_edge_pixel_search_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clamp_pos(input int v);
        if (v < 0)
            return 0;
        if (v > POS_LIMIT - 1)
            return POS_LIMIT - 1;
        return v;
    endfunction

    function automatic result_t nearest_edge(input int qx, input int qy);
        result_t res;
        int      best;
        int      x;
        int      y;
        int      d;
        res  = '0;
        best = 0;
        for (int r = 1; r <= SEARCH_RADIUS; r++)
        begin
            x = qx - r;
            y = qy - r;
            for (int s = 0; s < 4; s++)
            begin
                for (int k = 0; k < 2 * r; k++)
                begin
                    if (x >= 0 && y >= 0 && x < eff_cols && y < eff_rows && edge_img[y][x])
                    begin
                        d = (x - qx) * (x - qx) + (y - qy) * (y - qy);
                        if (!res.found || d < best)
                        begin
                            res.found     = 1'b1;
                            res.nearest_x = POS_W'(x);
                            res.nearest_y = POS_W'(y);
                            best          = d;
                        end
                    end
                    case (side_t'(s))
                        SIDE_RIGHT: x++;
                        SIDE_DOWN:  y++;
                        SIDE_LEFT:  x--;
                        default:    y--;
                    endcase
                end
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_idle || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return SIZE_W'($urandom_range(1, 24));
        if (p < 80)
            return SIZE_W'(512);
        if (p < 88)
            return SIZE_W'($urandom_range(25, 511));
        if (p < 95)
            return SIZE_W'($urandom_range(513, 1023));
        return '0;
    endfunction

    task automatic send_item(input item_t it, input bit typed, input result_t typed_exp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(negedge clk); while (busy);
        @(posedge clk);
        items_sent++;
        if (it.operation == OP_WRITE)
        begin
            edge_img[it.pos_y][it.pos_x]  = it.edge_bit;
            px_loaded[it.pos_y][it.pos_x] = 1'b1;
        end
        else
            nearest_due.push_back(typed ? typed_exp : nearest_edge(it.pos_x, it.pos_y));
    endtask

    task automatic send_write(input int x, input int y, input bit e);
        item_t it;
        it.operation = OP_WRITE;
        it.pos_x     = POS_W'(x);
        it.pos_y     = POS_W'(y);
        it.edge_bit  = e;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_query(input int x, input int y);
        item_t it;
        it.operation = OP_QUERY;
        it.pos_x     = POS_W'(x);
        it.pos_y     = POS_W'(y);
        it.edge_bit  = 1'($urandom_range(0, 1));
        send_item(it, 1'b0, '0);
    endtask

    // Every in-image pixel that a query can reach is written before the query goes out.
    task automatic load_window(input int qx, input int qy, input int density);
        for (int yy = qy - SEARCH_RADIUS; yy <= qy + SEARCH_RADIUS; yy++)
        begin
            for (int xx = qx - SEARCH_RADIUS; xx <= qx + SEARCH_RADIUS; xx++)
            begin
                if (xx >= 0 && yy >= 0 && xx < eff_cols && yy < eff_rows && !px_loaded[yy][xx])
                    send_write(xx, yy, $urandom_range(0, density - 1) == 0);
            end
        end
    endtask

    task automatic write_size_reg(input logic idx, input logic [SIZE_W-1:0] val);
        start <= 1'b0;
        do @(negedge clk); while (nearest_due.size() != 0 || busy);
        repeat ($urandom_range(1, 3)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_COLS)
            eff_cols = (int'(val) < COLS_LIM) ? int'(val) : COLS_LIM;
        else
            eff_rows = (int'(val) < ROWS_LIM) ? int'(val) : ROWS_LIM;
    endtask

    task automatic run_phase(input int ph);
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
        int                hx;
        int                hy;
        int                density;
        int                n_queries;
        int                qx;
        int                qy;
        int                pick;
        case (ph)
            0:       begin cols = 10'd512;  rows = 10'd512;  end
            1:       begin cols = 10'd1;    rows = 10'd512;  end
            2:       begin cols = 10'd0;    rows = 10'd9;    end
            3:       begin cols = 10'd1023; rows = 10'd1;    end
            4:       begin cols = 10'd16;   rows = 10'd1023; end
            5:       begin cols = 10'd3;    rows = 10'd3;    end
            default: begin cols = random_size(); rows = random_size(); end
        endcase
        write_size_reg(REG_IMAGE_COLS, cols);
        write_size_reg(REG_IMAGE_ROWS, rows);
        case ($urandom_range(0, 4))
            0:       density = 2;
            1:       density = 3;
            2:       density = 6;
            3:       density = 15;
            default: density = 50;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
        pick = (ph == 0) ? 1 : $urandom_range(0, 2);
        case (pick)
            0:
            begin
                hx = $urandom_range(0, 3);
                hy = $urandom_range(0, 3);
            end
            1:
            begin
                hx = clamp_pos(eff_cols - 4 + $urandom_range(0, 6));
                hy = clamp_pos(eff_rows - 4 + $urandom_range(0, 6));
            end
            default:
            begin
                hx = $urandom_range(0, clamp_pos(eff_cols + SEARCH_RADIUS));
                hy = $urandom_range(0, clamp_pos(eff_rows + SEARCH_RADIUS));
            end
        endcase
        n_queries = $urandom_range(15, 40);
        for (int i = 0; i < n_queries && items_sent < ITEM_TARGET; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_write(clamp_pos(hx + $urandom_range(0, 16) - 8),
                           clamp_pos(hy + $urandom_range(0, 16) - 8),
                           $urandom_range(0, density - 1) == 0);
            else if (pick < 18)
                send_write($urandom_range(0, POS_LIMIT - 1), $urandom_range(0, POS_LIMIT - 1),
                           $urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 88 || (eff_cols * eff_rows > 4096 && pick < 97))
            begin
                qx = clamp_pos(hx + $urandom_range(0, 12) - 6);
                qy = clamp_pos(hy + $urandom_range(0, 12) - 6);
            end
            else
            begin
                qx = $urandom_range(0, POS_LIMIT - 1);
                qy = $urandom_range(0, POS_LIMIT - 1);
            end
            load_window(qx, qy, density);
            send_query(qx, qy);
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (nearest_due.size() == 0)
            begin
                $error("result with no query outstanding: found %0d x %0d y %0d",
                       result.found, result.nearest_x, result.nearest_y);
                mismatches++;
            end
            else
            begin
                want = nearest_due.pop_front();
                if (result.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, result.found);
                    mismatches++;
                end
                if (result.nearest_x !== want.nearest_x)
                begin
                    $error("nearest_x: expected %0d, got %0d", want.nearest_x, result.nearest_x);
                    mismatches++;
                end
                if (result.nearest_y !== want.nearest_y)
                begin
                    $error("nearest_y: expected %0d, got %0d", want.nearest_y, result.nearest_y);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        item_t     it;
        // Row layout: kind, value or column, row, edge bit, typed flag, typed found/x/y.
        dir_rows.push_back({ROW_ROWS,  10'd1,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd0,    9'd0,   1'b1, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd1,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd2,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd3,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd4,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd5,    9'd0,   1'b1, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_QUERY, 10'd0,    9'd0,   1'b0, 1'b1, 1'b1, 9'd5, 9'd0});
        dir_rows.push_back({ROW_QUERY, 10'd0,    9'd3,   1'b1, 1'b1, 1'b1, 9'd0, 9'd0});
        dir_rows.push_back({ROW_QUERY, 10'd0,    9'd6,   1'b0, 1'b1, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_COLS,  10'd1,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_QUERY, 10'd0,    9'd0,   1'b0, 1'b1, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_QUERY, 10'd5,    9'd5,   1'b0, 1'b1, 1'b1, 9'd0, 9'd0});
        dir_rows.push_back({ROW_QUERY, 10'd511,  9'd511, 1'b1, 1'b1, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_COLS,  10'd0,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_QUERY, 10'd1,    9'd1,   1'b0, 1'b1, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_COLS,  10'd1023, 9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd6,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd7,    9'd0,   1'b1, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd8,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_QUERY, 10'd3,    9'd0,   1'b0, 1'b0, 1'b0, 9'd0, 9'd0});
        dir_rows.push_back({ROW_WRITE, 10'd511,  9'd511, 1'b1, 1'b0, 1'b0, 9'd0, 9'd0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            case (row.kind)
                ROW_COLS: write_size_reg(REG_IMAGE_COLS, row.val);
                ROW_ROWS: write_size_reg(REG_IMAGE_ROWS, row.val);
                default:
                begin
                    it.operation = (row.kind == ROW_WRITE) ? OP_WRITE : OP_QUERY;
                    it.pos_x     = row.val[POS_W-1:0];
                    it.pos_y     = row.y;
                    it.edge_bit  = row.e;
                    send_item(it, row.typed, row.exp);
                end
            endcase
        end

        for (int ph = 0; items_sent < ITEM_TARGET; ph++)
            run_phase(ph);

        start <= 1'b0;
        do @(negedge clk); while (nearest_due.size() != 0 || busy);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- nearest_edge_pixel_search_unit.f -----
sv/neps_pkg.sv
sv/neps_ram.sv
sv/neps_ctrl.sv
sv/neps_dp.sv
sv/nearest_edge_pixel_search_unit.sv
sv/neps_checker.sv
tb/sv/nearest_edge_pixel_search_unit_tb.sv
